// ===== src/swo_pkg.sv =====
// swo_pkg: shared constants, register indexes and the sine lookup for the
// scanline sine-wave offset block. No dependencies.
`default_nettype none

package swo_pkg;

    // field widths
    localparam int LINE_W   = 8;
    localparam int SCROLL_W = 16;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // serial datapath: bits handled per cycle and step counts
    localparam int DIGIT_W    = 2;
    localparam int MUL_STEPS  = 8 / DIGIT_W;
    localparam int ADD_STEPS  = SCROLL_W / DIGIT_W;
    localparam int STEP_CNT_W = $clog2(ADD_STEPS);

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_START_LINE = 3'd0;
    localparam logic [2:0] REG_END_LINE   = 3'd1;
    localparam logic [2:0] REG_FREQUENCY  = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE  = 3'd3;
    localparam logic [2:0] REG_DELAY      = 3'd4;
    localparam logic [2:0] REG_USE_BASE   = 3'd5;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // quarter wave, 256*sin(2*pi*i/256) truncated, i = 0..64
    localparam logic [8:0] QUARTER_SINE [0:64] = '{
        9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
        9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
        9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
        9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
        9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
        9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
        9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
        9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
        9'd256
    };

    // magnitude of the sine at a 256-step index; sign is idx[7]
    function automatic logic [8:0] sine_mag(input logic [7:0] idx);
        logic [7:0] j;
        j = {1'b0, idx[6:0]};
        if (j > 8'd64)
            j = 8'd128 - j;
        return QUARTER_SINE[j[6:0]];
    endfunction

endpackage

`default_nettype wire

// ===== src/swo_if.sv =====
// swo_req_if / swo_res_if: valid/ready channels for requests and results
// of the scanline sine-wave offset block. No dependencies.
`default_nettype none

interface swo_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  line_index;
    logic [15:0] base_scroll;

    modport source (output valid, output req_type, output line_index,
                    output base_scroll, input ready);
    modport sink   (input valid, input req_type, input line_index,
                    input base_scroll, output ready);
endinterface

interface swo_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] offset_value;
    logic        in_window;

    modport source (output valid, output offset_value, output in_window,
                    input ready);
    modport sink   (input valid, input offset_value, input in_window,
                    output ready);
endinterface

`default_nettype wire

// ===== src/scanline_sine_wave_offset.sv =====
// scanline_sine_wave_offset: top level, per-scanline wavy scroll offsets
// depends on swo_pkg and the channel interfaces in swo_if.sv
`default_nettype none

// usage
//   req (sink): one request per handshake. a frame tick (req_type 0) latches
//   the base scroll and phase and, once the delay has run out, steps the
//   phase; a scanline query (req_type 1) asks for the offset of line_index.
//   res (source): one result per request, offset_value and in_window;
//   ticks and lines outside [start_line, end_line) answer zero.
//   apb: six registers at byte addresses 0x00..0x14; the user must write
//   them only while idle, the block itself leaves this unchecked.
// timing
//   one request in flight at a time. ticks and out-of-window queries go
//   straight to the hand-off; an in-window query passes through the sine
//   index product, the table read, the amplitude product (2 bits per cycle
//   each), the sign and scale step, the 2-bit serial add of the base and
//   the hand-off. the next request is accepted only once back in idle.
//   the result sits in an output register; a stalled receiver only holds
//   the block once the next result is ready to move into that register.
// reset
//   rst_n sets configuration and control registers to reset values: empty
//   window, frequency 1, amplitude 0, no delay, base scroll off, phase zero.

module scanline_sine_wave_offset
    import swo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    swo_req_if.sink                 req,
    swo_res_if.source               res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_NEG  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // configuration registers
    logic [7:0]  start_line_reg;
    logic [8:0]  end_line_reg;
    logic [7:0]  frequency_reg;
    logic [7:0]  amplitude_reg;
    logic [15:0] delay_frames_reg;
    logic        use_base_reg;

    // frame state
    logic [7:0]  wave_phase_reg,  wave_phase_next;
    logic [15:0] frames_left_reg, frames_left_next;
    logic [7:0]  shown_phase_reg, shown_phase_next;
    logic [15:0] shown_base_reg,  shown_base_next;

    // sequencer and serial datapath
    logic [2:0]            state_reg,   state_next;
    logic [STEP_CNT_W-1:0] cnt_reg,     cnt_next;
    logic [7:0]            k_sh_reg,    k_sh_next;
    logic [7:0]            f_sh_reg,    f_sh_next;
    logic [7:0]            idx_reg,     idx_next;
    logic [15:0]           mag_sh_reg,  mag_sh_next;
    logic [7:0]            a_sh_reg,    a_sh_next;
    logic                  neg_reg,     neg_next;
    logic [15:0]           prod_reg,    prod_next;
    logic [15:0]           wave_sh_reg, wave_sh_next;
    logic [15:0]           base_sh_reg, base_sh_next;
    logic                  carry_reg,   carry_next;
    logic [15:0]           res_sh_reg,  res_sh_next;
    logic                  win_reg,     win_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_offset_reg, out_offset_next;
    logic        out_win_reg,    out_win_next;

    logic        cfg_wr;
    logic        accept;
    logic        hit;
    logic [8:0]  phase_plus2;
    logic [16:0] wrap_prod;
    logic        wrap;
    logic [23:0] signed_prod;
    logic [2:0]  dsum;
    logic        out_load;

    // ---------------------------------------------------------------
    // apb register file
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_START_LINE: prdata = PDATA_W'(start_line_reg);
            REG_END_LINE:   prdata = PDATA_W'(end_line_reg);
            REG_FREQUENCY:  prdata = PDATA_W'(frequency_reg);
            REG_AMPLITUDE:  prdata = PDATA_W'(amplitude_reg);
            REG_DELAY:      prdata = PDATA_W'(delay_frames_reg);
            REG_USE_BASE:   prdata = PDATA_W'(use_base_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_line_reg   <= 8'd0;
            end_line_reg     <= 9'd0;
            frequency_reg    <= 8'd1;
            amplitude_reg    <= 8'd0;
            delay_frames_reg <= 16'd0;
            use_base_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_START_LINE: start_line_reg   <= pwdata[7:0];
                REG_END_LINE:   end_line_reg     <= pwdata[8:0];
                REG_FREQUENCY:  frequency_reg    <= pwdata[7:0];
                REG_AMPLITUDE:  amplitude_reg    <= pwdata[7:0];
                REG_DELAY:      delay_frames_reg <= pwdata[15:0];
                REG_USE_BASE:   use_base_reg     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;

    // window test; lines are 8 bits so the line count limit always holds
    assign hit = (req.line_index >= start_line_reg)
               && ({1'b0, req.line_index} < end_line_reg);

    // phase wrap: phase+1 >= floor(256/f)  <=>  (phase+2)*f > 256
    assign phase_plus2 = {1'b0, wave_phase_reg} + 9'd2;
    assign wrap_prod   = 17'(phase_plus2) * 17'(frequency_reg);
    assign wrap        = (frequency_reg == 8'd0) ? (wave_phase_reg == 8'hFF)
                                                 : (wrap_prod > 17'd256);

    // scaled, signed product: bits 23:8 of the 24-bit two's complement
    assign signed_prod = neg_reg ? (24'd0 - {8'd0, prod_reg}) : {8'd0, prod_reg};

    // one 2-bit digit of the base add
    assign dsum = {1'b0, wave_sh_reg[DIGIT_W-1:0]} + {1'b0, base_sh_reg[DIGIT_W-1:0]}
                + {2'b00, carry_reg};

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        k_sh_next        = k_sh_reg;
        f_sh_next        = f_sh_reg;
        idx_next         = idx_reg;
        mag_sh_next      = mag_sh_reg;
        a_sh_next        = a_sh_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        wave_sh_next     = wave_sh_reg;
        base_sh_next     = base_sh_reg;
        carry_next       = carry_reg;
        res_sh_next      = res_sh_reg;
        win_next         = win_reg;
        wave_phase_next  = wave_phase_reg;
        frames_left_next = frames_left_reg;
        shown_phase_next = shown_phase_reg;
        shown_base_next  = shown_base_reg;

        // a delay write restarts the frame countdown
        if (cfg_wr && (paddr[4:2] == REG_DELAY))
            frames_left_next = pwdata[15:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_sh_next = '0;
                    win_next    = 1'b0;
                    if (req.req_type == REQ_TICK)
                    begin
                        shown_base_next  = use_base_reg ? req.base_scroll : 16'd0;
                        shown_phase_next = wave_phase_reg;
                        if (frames_left_reg != 16'd0)
                            frames_left_next = frames_left_reg - 16'd1;
                        else
                            wave_phase_next = wrap ? 8'd0 : (wave_phase_reg + 8'd1);
                        state_next = S_DONE;
                    end
                    else if (hit)
                    begin
                        // wave index k, only its low 8 bits matter
                        k_sh_next  = shown_phase_reg + (req.line_index - start_line_reg);
                        f_sh_next  = frequency_reg;
                        idx_next   = 8'd0;
                        cnt_next   = STEP_CNT_W'(MUL_STEPS - 1);
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL1:
            begin
                // sine index = k * frequency mod 256, two multiplier bits a cycle
                idx_next  = idx_reg + 8'(k_sh_reg * 8'(f_sh_reg[DIGIT_W-1:0]));
                k_sh_next = k_sh_reg << DIGIT_W;
                f_sh_next = f_sh_reg >> DIGIT_W;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_LOOK;
            end

            S_LOOK:
            begin
                mag_sh_next = 16'(sine_mag(idx_reg));
                neg_next    = idx_reg[7];
                a_sh_next   = amplitude_reg;
                prod_next   = 16'd0;
                cnt_next    = STEP_CNT_W'(MUL_STEPS - 1);
                state_next  = S_MUL2;
            end

            S_MUL2:
            begin
                // |sine| * amplitude fits 16 bits
                prod_next   = prod_reg + 16'(mag_sh_reg * 16'(a_sh_reg[DIGIT_W-1:0]));
                mag_sh_next = mag_sh_reg << DIGIT_W;
                a_sh_next   = a_sh_reg >> DIGIT_W;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_NEG;
            end

            S_NEG:
            begin
                wave_sh_next = signed_prod[23:8];
                base_sh_next = shown_base_reg;
                carry_next   = 1'b0;
                cnt_next     = STEP_CNT_W'(ADD_STEPS - 1);
                state_next   = S_ADD;
            end

            S_ADD:
            begin
                // lsb-first digit add, sum enters at the top of the result
                res_sh_next  = {dsum[DIGIT_W-1:0], res_sh_reg[15:DIGIT_W]};
                wave_sh_next = wave_sh_reg >> DIGIT_W;
                base_sh_next = base_sh_reg >> DIGIT_W;
                carry_next   = dsum[DIGIT_W];
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    win_next   = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_offset_next = out_offset_reg;
        out_win_next    = out_win_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_offset_next = res_sh_reg;
            out_win_next    = win_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.offset_value = out_offset_reg;
    assign res.in_window    = out_win_reg;

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            wave_phase_reg  <= 8'd0;
            frames_left_reg <= 16'd0;
            shown_phase_reg <= 8'd0;
            shown_base_reg  <= 16'd0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            wave_phase_reg  <= wave_phase_next;
            frames_left_reg <= frames_left_next;
            shown_phase_reg <= shown_phase_next;
            shown_base_reg  <= shown_base_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        k_sh_reg       <= k_sh_next;
        f_sh_reg       <= f_sh_next;
        idx_reg        <= idx_next;
        mag_sh_reg     <= mag_sh_next;
        a_sh_reg       <= a_sh_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        wave_sh_reg    <= wave_sh_next;
        base_sh_reg    <= base_sh_next;
        carry_reg      <= carry_next;
        res_sh_reg     <= res_sh_next;
        win_reg        <= win_next;
        out_offset_reg <= out_offset_next;
        out_win_reg    <= out_win_next;
    end

endmodule

`default_nettype wire

// ===== test/scanline_sine_wave_offset_tb.sv =====
// scanline_sine_wave_offset_tb: self-checking bench for the wavy scroll offset block
// predicts every result from its own wave and phase model, drives apb and both channels
// depends on swo_pkg, swo_req_if / swo_res_if and scanline_sine_wave_offset
`timescale 1ns / 100ps

module scanline_sine_wave_offset_tb
    import swo_pkg::*;
();

    // no handshake of any kind for this long means the block is hung
    localparam int STALL_LIMIT = 4000;
    // idle margin at the very end, after the last result is back
    localparam int TAIL_CYCLES = 40;
    // long receiver hold-off used to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 400;
    // index with no register behind it, writes must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd6;

    // 256*sin(2*pi*i/256) truncated toward zero, first quarter incl. the peak
    localparam int QUARTER_WAVE [0:64] = '{
        0, 6, 12, 18, 25, 31, 37, 43, 49, 56, 62, 68, 74, 80, 86, 92,
        97, 103, 109, 115, 120, 126, 131, 136, 142, 147, 152, 157, 162, 167, 171, 176,
        181, 185, 189, 193, 197, 201, 205, 209, 212, 216, 219, 222, 225, 228, 231, 234,
        236, 238, 241, 243, 244, 246, 248, 249, 251, 252, 253, 254, 254, 255, 255, 255,
        256
    };

    typedef struct packed {
        logic [15:0] offset_value;
        logic        in_window;
    } offset_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // apb side
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    swo_req_if req_ch ();
    swo_res_if res_ch ();

    scanline_sine_wave_offset dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // offset predictor: register copy plus the frame state of the block
    // ------------------------------------------------------------------
    logic [7:0]  win_start;
    logic [8:0]  win_end;
    logic [7:0]  step_freq;
    logic [7:0]  amp_gain;
    logic [15:0] hold_frames;
    logic        base_enable;

    logic [7:0]  phase_now;
    logic [15:0] delay_left;
    logic [7:0]  latched_phase;
    logic [15:0] latched_base;
    logic [8:0]  phase_wrap;

    offset_result_t expected_offsets [$];

    int  mismatch_count = 0;
    int  result_count = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;
    int  result_hold_cycles = 0;

    // phase wraps at floor(256/freq); a zero step behaves like a full turn
    function automatic logic [8:0] wrap_for(input logic [7:0] freq);
        if (freq == 8'd0)
            return 9'd256;
        return 9'(256 / freq);
    endfunction

    function automatic void reset_model();
        win_start     = 8'd0;
        win_end       = 9'd0;
        step_freq     = 8'd1;
        amp_gain      = 8'd0;
        hold_frames   = 16'd0;
        base_enable   = 1'b0;
        phase_now     = 8'd0;
        delay_left    = 16'd0;
        latched_phase = 8'd0;
        latched_base  = 16'd0;
        phase_wrap    = wrap_for(8'd1);
    endfunction

    // signed sine sample, mirrored from the quarter table
    function automatic int sine_value(input logic [7:0] idx);
        int j;
        j = int'(idx[6:0]);
        if (j > 64)
            j = 128 - j;
        return idx[7] ? -QUARTER_WAVE[j] : QUARTER_WAVE[j];
    endfunction

    // wave sample for wave index k; the shift floors negative products
    function automatic logic [15:0] wave_at(input int unsigned k);
        int product;
        product = sine_value(8'(k * step_freq)) * int'(amp_gain);
        return product[23:8];
    endfunction

    function automatic void update_register(input logic [2:0] index,
                                            input logic [PDATA_W-1:0] value);
        case (index)
            REG_START_LINE: win_start = value[7:0];
            REG_END_LINE:   win_end = value[8:0];
            REG_FREQUENCY:
            begin
                step_freq  = value[7:0];
                phase_wrap = wrap_for(step_freq);
            end
            REG_AMPLITUDE:  amp_gain = value[7:0];
            REG_DELAY:
            begin
                hold_frames = value[15:0];
                delay_left  = hold_frames;
            end
            REG_USE_BASE:   base_enable = value[0];
            default: ;
        endcase
    endfunction

    // one request in, one offset out; ticks move the frame state
    function automatic offset_result_t predict_offset(input logic kind,
                                                      input logic [7:0] line_no,
                                                      input logic [15:0] base);
        offset_result_t r;
        int unsigned k;
        int next_phase;
        r.offset_value = 16'd0;
        r.in_window    = 1'b0;
        if (kind == REQ_TICK)
        begin
            latched_base  = base_enable ? base : 16'd0;
            latched_phase = phase_now;
            if (delay_left != 16'd0)
                delay_left = delay_left - 16'd1;
            else
            begin
                next_phase = int'(phase_now) + 1;
                phase_now  = (next_phase >= int'(phase_wrap)) ? 8'd0 : 8'(next_phase);
            end
        end
        else if (line_no >= win_start && {1'b0, line_no} < win_end)
        begin
            k = int'(latched_phase) + int'(line_no) - int'(win_start);
            r.offset_value = wave_at(k) + latched_base;
            r.in_window    = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // valid stays high across back-to-back requests; a gap lowers it
    task automatic send_request(input logic kind, input logic [7:0] line_no,
                                input logic [15:0] base);
        if (sender_gaps)
        begin
            while ($urandom_range(99) < 7)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.line_index  <= line_no;
        req_ch.base_scroll <= base;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // accepted at this edge, expectation is fixed now
        expected_offsets.push_back(predict_offset(kind, line_no, base));
    endtask

    // mostly in-window queries with random content, ticks and stray lines mixed in
    task automatic send_random_request();
        logic       kind;
        logic [7:0] line_no;
        int         hi_line;
        kind    = ($urandom_range(99) < 30) ? REQ_TICK : REQ_QUERY;
        line_no = 8'($urandom_range(255));
        if (kind == REQ_QUERY && win_end > {1'b0, win_start} && $urandom_range(99) < 80)
        begin
            hi_line = (win_end > 9'd256) ? 255 : int'(win_end) - 1;
            line_no = 8'($urandom_range(hi_line, int'(win_start)));
        end
        send_request(kind, line_no, 16'($urandom));
    endtask

    // sender pause: drop valid and wait until every result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_offsets.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // apb writes, setup then access phase
    // ------------------------------------------------------------------
    task automatic write_register(input logic [2:0] index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        update_register(index, value);
    endtask

    // full register set, only once the block has gone idle
    task automatic configure(input logic [7:0] first_line, input logic [8:0] last_line,
                             input logic [7:0] freq, input logic [7:0] gain,
                             input logic [15:0] frames, input logic base_on);
        drain_results();
        write_register(REG_START_LINE, 32'(first_line));
        write_register(REG_END_LINE, 32'(last_line));
        write_register(REG_FREQUENCY, 32'(freq));
        write_register(REG_AMPLITUDE, 32'(gain));
        write_register(REG_DELAY, 32'(frames));
        write_register(REG_USE_BASE, 32'(base_on));
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off on demand
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_hold_cycles != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (result_hold_cycles) @(posedge clk);
                result_hold_cycles = 0;
            end
            res_ch.ready <= !(receiver_gaps && $urandom_range(99) < 7);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        offset_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_offsets.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("result %0d with no request pending: offset %h in_window %b",
                             result_count, res_ch.offset_value, res_ch.in_window);
                mismatch_count++;
            end
            else
            begin
                want = expected_offsets.pop_front();
                if (res_ch.offset_value !== want.offset_value ||
                    res_ch.in_window !== want.in_window)
                begin
                    if (mismatch_count < 10)
                        $display("result %0d: expected offset %h in_window %b, got %h %b",
                                 result_count, want.offset_value, want.in_window,
                                 res_ch.offset_value, res_ch.in_window);
                    mismatch_count++;
                end
            end
            result_count++;
        end
    end

    // hang detector: counts cycles in which nothing moves on any port
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (req_ch.valid && req_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no request or result moved for %0d cycles", STALL_LIMIT);
        $display("scanline_sine_wave_offset verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: empty window, base scroll off so a tick base is dropped
    task automatic test_reset_defaults();
        send_request(REQ_TICK, 8'd0, 16'hFFFF);
        send_request(REQ_QUERY, 8'd0, 16'h0000);
        send_request(REQ_QUERY, 8'd255, 16'hFFFF);
    endtask

    // full window, full amplitude, max base: peaks and troughs wrap mod 2^16
    task automatic test_window_extremes();
        configure(8'd0, 9'd256, 8'd1, 8'd255, 16'd0, 1'b1);
        send_request(REQ_TICK, 8'd0, 16'hFFFF);
        send_request(REQ_QUERY, 8'd0, 16'd0);
        send_request(REQ_QUERY, 8'd64, 16'd0);
        send_request(REQ_QUERY, 8'd128, 16'd0);
        send_request(REQ_QUERY, 8'd192, 16'd0);
        send_request(REQ_QUERY, 8'd255, 16'd0);
    endtask

    // one-line window edges and a frame delay before the phase moves
    task automatic test_phase_delay();
        configure(8'd100, 9'd101, 8'd3, 8'd128, 16'd2, 1'b0);
        send_request(REQ_TICK, 8'd0, 16'h1234);
        send_request(REQ_QUERY, 8'd99, 16'd0);
        send_request(REQ_QUERY, 8'd100, 16'd0);
        send_request(REQ_QUERY, 8'd101, 16'd0);
        send_request(REQ_TICK, 8'd0, 16'd0);
        send_request(REQ_TICK, 8'd0, 16'd0);
        send_request(REQ_TICK, 8'd0, 16'd0);
        send_request(REQ_QUERY, 8'd100, 16'd0);
    endtask

    // zero frequency, window with end below start, dropped register write
    task automatic test_zero_frequency();
        configure(8'd200, 9'd50, 8'd0, 8'd200, 16'd0, 1'b1);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_request(REQ_TICK, 8'd0, 16'h8001);
        send_request(REQ_QUERY, 8'd200, 16'd0);
        send_request(REQ_QUERY, 8'd49, 16'd0);
        configure(8'd255, 9'd256, 8'd0, 8'd200, 16'd0, 1'b1);
        send_request(REQ_QUERY, 8'd255, 16'd0);
        send_request(REQ_QUERY, 8'd254, 16'd0);
    endtask

    // receiver holds off long enough that the block fills and stalls requests
    task automatic test_backpressure();
        configure(8'd0, 9'd256, 8'd7, 8'd181, 16'd0, 1'b1);
        sender_gaps = 1'b0;
        result_hold_cycles = HOLD_OFF_CYCLES;
        repeat (20) send_random_request();
        // pause until everything is back, then carry on
        drain_results();
        sender_gaps = 1'b1;
        repeat (10) send_random_request();
    endtask

    // random content across a series of register settings, extremes first
    task automatic test_random_settings();
        logic [7:0] first_line;
        logic [8:0] last_line;
        int         sel;
        for (int stage = 0; stage < 12; stage++)
        begin
            first_line = 8'($urandom_range(200));
            sel        = $urandom_range(9);
            // mostly real windows, sometimes full or empty
            if (sel < 6)
                last_line = 9'(int'(first_line) + $urandom_range(56, 1));
            else if (sel < 8)
                last_line = 9'd256;
            else
                last_line = 9'($urandom_range(int'(first_line)));
            case (stage)
                0: configure(8'd0, 9'd256, 8'd255, 8'd255, 16'd0, 1'b1);
                1: configure(8'd255, 9'd256, 8'd1, 8'd255, 16'd0, 1'b1);
                2: configure(8'd0, 9'd256, 8'd0, 8'd128, 16'd1, 1'b1);
                3: configure(first_line, last_line, 8'd2, 8'd255, 16'hFFFF, 1'b1);
                4: configure(8'd0, 9'h1FF, 8'd1, 8'd0, 16'd0, 1'b0);
                default:
                    configure(first_line, last_line, 8'($urandom_range(255, 1)),
                              8'($urandom_range(255)), 16'($urandom_range(3)),
                              1'($urandom_range(1)));
            endcase
            // one long stretch with no idling on either side
            sender_gaps   = (stage != 5);
            receiver_gaps = (stage != 5);
            repeat (75) send_random_request();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_TICK;
        req_ch.line_index  <= 8'd0;
        req_ch.base_scroll <= 16'd0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_window_extremes();
        test_phase_delay();
        test_zero_frequency();
        test_backpressure();
        test_random_settings();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_offsets.size() == 0)
            $display("scanline_sine_wave_offset verification clean");
        else
            $display("scanline_sine_wave_offset verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/swo_pkg.sv
src/swo_if.sv
src/scanline_sine_wave_offset.sv
test/scanline_sine_wave_offset_tb.sv
